// ===== rtl/dstd_pkg.sv =====
// dstd_pkg: shared widths, codes and divider request/response types
// for the dual sensor twist detector; depends on nothing
`default_nettype none

package dstd_pkg;

    localparam int DELTA_WIDTH = 16;
    localparam int CFG_WIDTH   = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int EXT_W       = DELTA_WIDTH + 1;
    localparam int CMP_W       = (EXT_W > CFG_WIDTH) ? EXT_W : CFG_WIDTH;

    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIVISOR   = 1'd1;

    localparam logic [1:0] SRC_A = 2'd0;
    localparam logic [1:0] SRC_B = 2'd1;

    localparam logic [1:0] IN_AXIS_X = 2'd0;
    localparam logic [1:0] IN_AXIS_Y = 2'd1;

    localparam logic [1:0] AXIS_X     = 2'd0;
    localparam logic [1:0] AXIS_Y     = 2'd1;
    localparam logic [1:0] AXIS_WHEEL = 2'd2;
    localparam logic [1:0] AXIS_OTHER = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                   start;
        logic [DELTA_WIDTH-1:0] dividend;
        logic [CFG_WIDTH-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic                   done;
        logic [DELTA_WIDTH-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/dual_sensor_twist_detector.sv =====
// dual_sensor_twist_detector: twist detection across two sensor Y deltas
// path: a pass-through word goes IDLE, DONE, output register; a relative Y word from source
// A or B goes IDLE, DIFF, CHECK, then DONE (unmatched) or DIV, DONE (twist), waiting in DIV on
// the bit-serial divider, one bit a cycle; DONE stalls until the output register is free
// throughput: one word in work at a time; a new word is taken only back in IDLE
// reset: synchronous active low, clears both stored deltas and both registers
`default_nettype none

module dual_sensor_twist_detector
    import dstd_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic                   s_is_relative,
    input  wire logic [1:0]             s_source,
    input  wire logic [1:0]             s_axis,
    input  wire logic [DELTA_WIDTH-1:0] s_value,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic                        m_forward,
    output logic [1:0]                  m_out_axis,
    output logic [DELTA_WIDTH-1:0]      m_out_value,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_WIDTH-1:0]   cfg_data
);

    state_t                 state_reg, state_next;
    logic                   m_valid_reg, m_valid_next;
    logic [DELTA_WIDTH-1:0] a_reg, a_next;
    logic [DELTA_WIDTH-1:0] b_reg, b_next;
    logic [CFG_WIDTH-1:0]   tol_reg, tol_next;
    logic [CFG_WIDTH-1:0]   div_reg, div_next;

    logic                   m_forward_reg, m_forward_next;
    logic [1:0]             m_axis_reg, m_axis_next;
    logic [DELTA_WIDTH-1:0] m_value_reg, m_value_next;
    logic                   res_fwd_reg, res_fwd_next;
    logic [1:0]             res_axis_reg, res_axis_next;
    logic [DELTA_WIDTH-1:0] res_value_reg, res_value_next;
    logic                   neg_reg, neg_next;
    logic [EXT_W-1:0]       diff_reg, diff_next;
    logic [EXT_W-1:0]       sum_reg, sum_next;

    logic [EXT_W-1:0]       a_ext, b_ext;
    logic [EXT_W-1:0]       abs_diff, sum_mag;
    logic                   twist;
    logic                   y_event;
    logic [1:0]             pass_axis;
    logic                   out_free;
    div_req_t               div_req;
    div_rsp_t               div_rsp;

    dstd_serdiv u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        a_ext    = {a_reg[DELTA_WIDTH-1], a_reg};
        b_ext    = {b_reg[DELTA_WIDTH-1], b_reg};
        abs_diff = diff_reg[EXT_W-1] ? (EXT_W'(0) - diff_reg) : diff_reg;
        sum_mag  = sum_reg[EXT_W-1] ? (EXT_W'(0) - sum_reg) : sum_reg;
        twist    = (a_reg != '0) && (b_reg != '0)
                   && (a_reg[DELTA_WIDTH-1] == b_reg[DELTA_WIDTH-1])
                   && (CMP_W'(abs_diff) <= CMP_W'(tol_reg));
        y_event  = s_is_relative && ((s_source == SRC_A) || (s_source == SRC_B))
                   && (s_axis == IN_AXIS_Y);
        if (!s_is_relative) begin
            pass_axis = AXIS_OTHER;
        end else if (s_axis == IN_AXIS_X) begin
            pass_axis = (s_source == SRC_B) ? AXIS_Y : AXIS_X;
        end else if (s_axis == IN_AXIS_Y) begin
            pass_axis = AXIS_Y;
        end else begin
            pass_axis = AXIS_OTHER;
        end
        out_free = !m_valid_reg || m_ready;
    end

    always_comb begin
        state_next       = state_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        a_next           = a_reg;
        b_next           = b_reg;
        tol_next         = tol_reg;
        div_next         = div_reg;
        m_forward_next   = m_forward_reg;
        m_axis_next      = m_axis_reg;
        m_value_next     = m_value_reg;
        res_fwd_next     = res_fwd_reg;
        res_axis_next    = res_axis_reg;
        res_value_next   = res_value_reg;
        neg_next         = neg_reg;
        diff_next        = diff_reg;
        sum_next         = sum_reg;
        div_req.start    = 1'b0;
        div_req.dividend = sum_mag[DELTA_WIDTH:1];
        div_req.divisor  = (div_reg == '0) ? CFG_WIDTH'(1) : div_reg;
        s_ready          = (state_reg == ST_IDLE);

        if (cfg_valid) begin
            case (cfg_index)
                REG_TOLERANCE: tol_next = cfg_data;
                REG_DIVISOR:   div_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (y_event) begin
                        if (s_source == SRC_A) begin
                            a_next = s_value;
                        end else begin
                            b_next = s_value;
                        end
                        state_next = ST_DIFF;
                    end else begin
                        res_fwd_next   = 1'b1;
                        res_axis_next  = pass_axis;
                        res_value_next = s_value;
                        state_next     = ST_DONE;
                    end
                end
            end
            ST_DIFF: begin
                diff_next  = a_ext - b_ext;
                sum_next   = a_ext + b_ext;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (twist) begin
                    div_req.start = 1'b1;
                    neg_next      = sum_reg[EXT_W-1];
                    a_next        = '0;
                    b_next        = '0;
                    state_next    = ST_DIV;
                end else begin
                    res_fwd_next   = 1'b0;
                    res_axis_next  = AXIS_X;
                    res_value_next = '0;
                    state_next     = ST_DONE;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    res_fwd_next   = 1'b1;
                    res_axis_next  = AXIS_WHEEL;
                    res_value_next = neg_reg ? (DELTA_WIDTH'(0) - div_rsp.quotient)
                                             : div_rsp.quotient;
                    state_next     = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_forward_next = res_fwd_reg;
                    m_axis_next    = res_axis_reg;
                    m_value_next   = res_value_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            a_reg       <= '0;
            b_reg       <= '0;
            tol_reg     <= '0;
            div_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            a_reg       <= a_next;
            b_reg       <= b_next;
            tol_reg     <= tol_next;
            div_reg     <= div_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_forward_reg <= m_forward_next;
        m_axis_reg    <= m_axis_next;
        m_value_reg   <= m_value_next;
        res_fwd_reg   <= res_fwd_next;
        res_axis_reg  <= res_axis_next;
        res_value_reg <= res_value_next;
        neg_reg       <= neg_next;
        diff_reg      <= diff_next;
        sum_reg       <= sum_next;
    end

    assign cfg_ready   = 1'b1;
    assign m_valid     = m_valid_reg;
    assign m_forward   = m_forward_reg;
    assign m_out_axis  = m_axis_reg;
    assign m_out_value = m_value_reg;

    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second word taken while one is in work");
    a_start_in_check: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> (state_reg == ST_CHECK))
        else $error("divider started outside the twist check");
    a_stores_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && div_rsp.done) |=> (a_reg == '0 && b_reg == '0))
        else $error("stored deltas not cleared after a twist");
    a_swallow_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_forward) |-> (m_out_axis == AXIS_X && m_out_value == '0))
        else $error("swallowed word carries data");

endmodule

`default_nettype wire

// ===== rtl/dstd_serdiv.sv =====
// dstd_serdiv: bit-serial restoring divider, one quotient bit per cycle
// depends on dstd_pkg
`default_nettype none

module dstd_serdiv
    import dstd_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int CNT_W = $clog2(DELTA_WIDTH + 1);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CFG_WIDTH-1:0]   rem_reg, rem_next;
    logic [DELTA_WIDTH-1:0] quo_reg, quo_next;
    logic [CFG_WIDTH-1:0]   dvs_reg, dvs_next;
    logic [CFG_WIDTH:0]     trial;
    logic                   fits;

    always_comb begin
        trial     = {rem_reg, quo_reg[DELTA_WIDTH-1]};
        fits      = (trial >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DELTA_WIDTH);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = CFG_WIDTH'(trial - {1'b0, dvs_reg});
            end else begin
                rem_next = trial[CFG_WIDTH-1:0];
            end
            quo_next = {quo_reg[DELTA_WIDTH-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("divider done held longer than one cycle");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(done_reg) |-> $past(busy_reg))
        else $error("divider done without a division");

endmodule

`default_nettype wire
